/* rtl/core/ctse_pkg.sv */
// shared types, key codes and field codes for the clock time set editor
package ctse_pkg;

    // key codes
    localparam logic [1:0] OP_SET   = 2'd0;
    localparam logic [1:0] OP_ADD   = 2'd1;
    localparam logic [1:0] OP_MINUS = 2'd2;

    // field codes
    localparam logic [2:0] FLD_IDLE   = 3'd0;
    localparam logic [2:0] FLD_YEAR   = 3'd1;
    localparam logic [2:0] FLD_MONTH  = 3'd2;
    localparam logic [2:0] FLD_DAY    = 3'd3;
    localparam logic [2:0] FLD_HOUR   = 3'd4;
    localparam logic [2:0] FLD_MINUTE = 3'd5;
    localparam logic [2:0] FLD_SECOND = 3'd6;

    // reset contents of the edit fields
    localparam logic [6:0] RST_YEAR   = 7'd17;
    localparam logic [3:0] RST_MONTH  = 4'd7;
    localparam logic [4:0] RST_DAY    = 5'd20;
    localparam logic [4:0] RST_HOUR   = 5'd17;
    localparam logic [5:0] RST_MINUTE = 6'd20;
    localparam logic [5:0] RST_SECOND = 6'd0;

    typedef struct packed {
        logic [1:0] op;
        logic [6:0] now_year;
        logic [3:0] now_month;
        logic [4:0] now_day;
        logic [4:0] now_hour;
        logic [5:0] now_minute;
        logic [5:0] now_second;
    } key_t;

    typedef struct packed {
        logic [2:0] edit_field;
        logic       tens_selected;
        logic [6:0] year_value;
        logic [3:0] month_value;
        logic [4:0] day_value;
        logic [4:0] hour_value;
        logic [5:0] minute_value;
        logic [5:0] second_value;
        logic       commit;
    } result_t;

    typedef struct packed {
        logic [2:0] field;
        logic       tens;
        logic [6:0] year;
        logic [3:0] month;
        logic [4:0] day;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } edit_state_t;

endpackage

/* rtl/core/ctse_if.sv */
// valid/ready channels for key requests and editor results
interface ctse_key_if;
    logic              valid;
    logic              ready;
    ctse_pkg::key_t    data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface ctse_result_if;
    logic              valid;
    logic              ready;
    ctse_pkg::result_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* rtl/core/clock_time_set_editor_top.sv */
// clock time set editor: key register, edit state, result register
// an accepted key request moves on into the result register once that is free
// throughput: one key request per cycle while results are taken; the edit state updates in one pass
// key ready follows result ready combinationally while both registers are full
// reset: asynchronous, active low; idle, units digit, fields 17/7/20 17:20:00
module clock_time_set_editor_top (
    input  logic               clk,
    input  logic               rst_n,
    ctse_key_if.sink           keys,
    ctse_result_if.source      result
);
    import ctse_pkg::*;

    // key register stage
    logic        in_valid_reg;
    key_t        in_data_reg;

    // result register stage
    logic        out_valid_reg;
    result_t     out_data_reg;

    // edit state, written as each request moves into the result register
    edit_state_t state_reg;
    edit_state_t state_next;
    logic        commit_next;

    logic        advance;
    logic        out_free;

    // the result register frees up when empty or when its content is taken
    assign out_free    = !out_valid_reg || result.ready;
    // a buffered key request moves on whenever the result register can take it
    assign advance     = in_valid_reg && out_free;
    assign keys.ready  = !in_valid_reg || out_free;

    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

    ctse_step u_step (
        .cur    (state_reg),
        .key    (in_data_reg),
        .nxt    (state_next),
        .commit (commit_next)
    );

    // control state and edit fields
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            state_reg.field  <= FLD_IDLE;
            state_reg.tens   <= 1'b0;
            state_reg.year   <= RST_YEAR;
            state_reg.month  <= RST_MONTH;
            state_reg.day    <= RST_DAY;
            state_reg.hour   <= RST_HOUR;
            state_reg.minute <= RST_MINUTE;
            state_reg.second <= RST_SECOND;
        end
        else
        begin
            if (keys.ready)
                in_valid_reg <= keys.valid;
            if (out_free)
                out_valid_reg <= in_valid_reg;
            if (advance)
                state_reg <= state_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (keys.ready && keys.valid)
            in_data_reg <= keys.data;
        if (advance)
        begin
            out_data_reg.edit_field    <= state_next.field;
            out_data_reg.tens_selected <= state_next.tens;
            out_data_reg.year_value    <= state_next.year;
            out_data_reg.month_value   <= state_next.month;
            out_data_reg.day_value     <= state_next.day;
            out_data_reg.hour_value    <= state_next.hour;
            out_data_reg.minute_value  <= state_next.minute;
            out_data_reg.second_value  <= state_next.second;
            out_data_reg.commit        <= commit_next;
        end
    end

endmodule

/* rtl/core/ctse_step.sv */
// next-state logic of the editor for one key request
module ctse_step (
    input  ctse_pkg::edit_state_t cur,
    input  ctse_pkg::key_t        key,
    output ctse_pkg::edit_state_t nxt,
    output logic                  commit
);
    import ctse_pkg::*;

    // leap rule on a two-digit year collapses to divisibility by four
    function automatic logic [6:0] month_days(input logic [3:0] m, input logic [6:0] y);
        logic [6:0] d;
        begin
            unique case (m)
                4'd4, 4'd6, 4'd9, 4'd11: d = 7'd30;
                4'd2:                    d = (y[1:0] == 2'b00) ? 7'd29 : 7'd28;
                default:                 d = 7'd31;
            endcase
            return d;
        end
    endfunction

    // step only when the result stays within lo..hi
    function automatic logic [6:0] bounded(input logic [6:0] v, input logic up,
                                           input logic [6:0] st, input logic [6:0] lo,
                                           input logic [6:0] hi);
        logic [7:0] sum;
        logic [6:0] dif;
        logic [6:0] r;
        begin
            sum = {1'b0, v} + {1'b0, st};
            dif = v - st;
            r   = v;
            if (up)
            begin
                if (sum <= {1'b0, hi})
                    r = sum[6:0];
            end
            else
            begin
                if (v >= st && dif >= lo)
                    r = dif;
            end
            return r;
        end
    endfunction

    logic [6:0] step;
    logic       up;
    logic [7:0] year_sum;
    logic [7:0] year_wrap;
    logic [7:0] load_year;
    logic [6:0] day_hi;
    logic [6:0] res;

    always_comb
    begin
        nxt       = cur;
        commit    = 1'b0;
        step      = cur.tens ? 7'd10 : 7'd1;
        up        = (key.op == OP_ADD);
        year_sum  = {1'b0, cur.year} + {1'b0, step};
        year_wrap = (year_sum >= 8'd100) ? year_sum - 8'd100 : year_sum;
        load_year = ({1'b0, key.now_year} >= 8'd100) ? {1'b0, key.now_year} - 8'd100
                                                      : {1'b0, key.now_year};
        day_hi    = month_days(cur.month, cur.year);
        res       = 7'd0;

        unique case (key.op)
            OP_SET:
            begin
                if (cur.field == FLD_IDLE)
                begin
                    nxt.year   = load_year[6:0];
                    nxt.month  = key.now_month;
                    nxt.day    = key.now_day;
                    nxt.hour   = key.now_hour;
                    nxt.minute = key.now_minute;
                    nxt.second = key.now_second;
                    nxt.tens   = 1'b1;
                    nxt.field  = FLD_YEAR;
                end
                else if (cur.tens)
                begin
                    nxt.tens = 1'b0;
                end
                else
                begin
                    nxt.tens = 1'b1;
                    if (cur.field >= FLD_SECOND)
                    begin
                        commit    = 1'b1;
                        nxt.field = FLD_IDLE;
                    end
                    else
                    begin
                        nxt.field = cur.field + 3'd1;
                    end
                end
            end
            OP_ADD, OP_MINUS:
            begin
                unique case (cur.field)
                    FLD_YEAR:
                    begin
                        if (up)
                            nxt.year = year_wrap[6:0];
                        else
                            nxt.year = (cur.year >= step) ? cur.year - step : 7'd99;
                    end
                    FLD_MONTH:
                    begin
                        res       = bounded({3'd0, cur.month}, up, step, 7'd1, 7'd12);
                        nxt.month = res[3:0];
                    end
                    FLD_DAY:
                    begin
                        res     = bounded({2'd0, cur.day}, up, step, 7'd1, day_hi);
                        nxt.day = res[4:0];
                    end
                    FLD_HOUR:
                    begin
                        res      = bounded({2'd0, cur.hour}, up, step, 7'd0, 7'd23);
                        nxt.hour = res[4:0];
                    end
                    FLD_MINUTE:
                    begin
                        res        = bounded({1'b0, cur.minute}, up, step, 7'd0, 7'd59);
                        nxt.minute = res[5:0];
                    end
                    FLD_SECOND:
                    begin
                        res        = bounded({1'b0, cur.second}, up, step, 7'd0, 7'd59);
                        nxt.second = res[5:0];
                    end
                    default:
                    begin
                        res = 7'd0;
                    end
                endcase
            end
            default:
            begin
                res = 7'd0;
            end
        endcase
    end

endmodule

/* test/tb.sv */
// testbench for the clock time set editor: directed and random key requests, checked against a local model
module tb;
    import ctse_pkg::*;

    // key code with no action, absent from the package
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam int RANDOM_KEYS    = 1450;
    localparam int WATCHDOG_LIMIT = 2000;
    // a result only passes the key and result registers, so a short tail is plenty
    localparam int TAIL_CYCLES    = 10;

    logic clk;
    logic rst_n;

    ctse_key_if    keys_if ();
    ctse_result_if result_if ();

    clock_time_set_editor_top u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .keys   (keys_if),
        .result (result_if)
    );

    // key requests waiting to be driven, and the results they should give
    key_t        pending_keys[$];
    result_t     expected_results[$];
    // local copy of the editor state
    edit_state_t editor;

    logic key_taken;
    int   total_keys;
    int   keys_accepted;
    int   quiet_cycles;
    int   errors;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // length of a month; the leap rule works on the two-digit year as it stands,
    // so year 0 counts as a leap year; a month outside 1..12 is taken as 31 days
    function automatic int month_days(int m, int y);
        case (m)
            1, 3, 5, 7, 8, 10, 12: return 31;
            4, 6, 9, 11:           return 30;
            2:                     return (((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0))
                                          ? 29 : 28;
            default:               return 31;
        endcase
    endfunction

    // a step only happens when the result stays within lo..hi
    function automatic int clamp_step(int v, bit up, int step, int lo, int hi);
        if (up)
            return (v + step <= hi) ? v + step : v;
        return (v >= step && v - step >= lo) ? v - step : v;
    endfunction

    // applies one key request to the local state and returns the result it shows
    function automatic result_t edit_step(key_t k);
        result_t r;
        int      step;
        bit      up;
        int      y;
        r.commit = 1'b0;
        step     = editor.tens ? 10 : 1;
        up       = (k.op == OP_ADD);
        case (k.op)
            OP_SET:
            begin
                if (editor.field == FLD_IDLE)
                begin
                    // take a snapshot of the running clock, year folded into two digits
                    editor.year   = 7'(int'(k.now_year) % 100);
                    editor.month  = k.now_month;
                    editor.day    = k.now_day;
                    editor.hour   = k.now_hour;
                    editor.minute = k.now_minute;
                    editor.second = k.now_second;
                    editor.tens   = 1'b1;
                    editor.field  = FLD_YEAR;
                end
                else if (editor.tens)
                    editor.tens = 1'b0;
                else
                begin
                    editor.tens = 1'b1;
                    if (editor.field >= FLD_SECOND)
                    begin
                        r.commit     = 1'b1;
                        editor.field = FLD_IDLE;
                    end
                    else
                        editor.field = editor.field + 3'd1;
                end
            end
            OP_ADD, OP_MINUS:
            begin
                case (editor.field)
                    FLD_YEAR:
                    begin
                        // year wraps upwards, and goes to 99 when stepping below zero
                        y = editor.year;
                        if (up)
                            y = (y + step) % 100;
                        else
                            y = (y >= step) ? y - step : 99;
                        editor.year = 7'(y);
                    end
                    FLD_MONTH:
                        editor.month = 4'(clamp_step(editor.month, up, step, 1, 12));
                    FLD_DAY:
                        editor.day = 5'(clamp_step(editor.day, up, step, 1,
                                                   month_days(editor.month, editor.year)));
                    FLD_HOUR:
                        editor.hour = 5'(clamp_step(editor.hour, up, step, 0, 23));
                    FLD_MINUTE:
                        editor.minute = 6'(clamp_step(editor.minute, up, step, 0, 59));
                    FLD_SECOND:
                        editor.second = 6'(clamp_step(editor.second, up, step, 0, 59));
                    default: ;
                endcase
            end
            default: ;
        endcase
        r.edit_field    = editor.field;
        r.tens_selected = editor.tens;
        r.year_value    = editor.year;
        r.month_value   = editor.month;
        r.day_value     = editor.day;
        r.hour_value    = editor.hour;
        r.minute_value  = editor.minute;
        r.second_value  = editor.second;
        return r;
    endfunction

    // key request with the time inputs spread over their full widths
    function automatic key_t random_key(logic [1:0] op);
        key_t k;
        k            = key_t'({$urandom, $urandom});
        k.op         = op;
        return k;
    endfunction

    function automatic void add_op(logic [1:0] op);
        pending_keys.push_back(random_key(op));
    endfunction

    function automatic void add_load(int y, int m, int d, int h, int mi, int s);
        key_t k;
        k            = random_key(OP_SET);
        k.now_year   = 7'(y);
        k.now_month  = 4'(m);
        k.now_day    = 5'(d);
        k.now_hour   = 5'(h);
        k.now_minute = 6'(mi);
        k.now_second = 6'(s);
        pending_keys.push_back(k);
    endfunction

    function automatic void add_sets(int n);
        repeat (n) add_op(OP_SET);
    endfunction

    function automatic void add_edits(int n);
        int pick;
        repeat (n)
        begin
            pick = $urandom_range(19);
            if (pick == 0)
                add_op(OP_UNUSED);
            else if (pick < 10)
                add_op(OP_ADD);
            else
                add_op(OP_MINUS);
        end
    endfunction

    // idle phases: sender idles lightly while the receiver stalls hard,
    // then the roles swap, and the last third runs flat out
    function automatic int idle_phase();
        if (keys_accepted < total_keys / 3)
            return 0;
        if (keys_accepted < 2 * total_keys / 3)
            return 1;
        return 2;
    endfunction

    function automatic bit sender_pause();
        case (idle_phase())
            0:       return $urandom_range(99) < 19;
            1:       return $urandom_range(99) < 56;
            default: return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_pause();
        case (idle_phase())
            0:       return $urandom_range(99) < 56;
            1:       return $urandom_range(99) < 19;
            default: return 1'b0;
        endcase
    endfunction

    task automatic check_field(string name, logic [6:0] want, logic [6:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    // driver: a new request goes out at the falling edge once the last one was taken
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!keys_if.valid || key_taken)
            begin
                if (pending_keys.size() != 0 && !sender_pause())
                begin
                    keys_if.valid <= 1'b1;
                    keys_if.data  <= pending_keys.pop_front();
                end
                else
                    keys_if.valid <= 1'b0;
            end
            result_if.ready <= !receiver_pause();
        end
    end

    // monitor: prediction on each accepted request, then checking of each accepted result;
    // both in one block so a prediction is always queued before its result can be seen
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n)
        begin
            key_taken <= keys_if.valid && keys_if.ready;
            if (keys_if.valid && keys_if.ready)
            begin
                expected_results.push_back(edit_step(keys_if.data));
                keys_accepted++;
            end
            if (result_if.valid && result_if.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result with no request outstanding");
                    errors++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("edit_field", want.edit_field, result_if.data.edit_field);
                    check_field("tens_selected", want.tens_selected,
                                result_if.data.tens_selected);
                    check_field("year_value", want.year_value, result_if.data.year_value);
                    check_field("month_value", want.month_value, result_if.data.month_value);
                    check_field("day_value", want.day_value, result_if.data.day_value);
                    check_field("hour_value", want.hour_value, result_if.data.hour_value);
                    check_field("minute_value", want.minute_value,
                                result_if.data.minute_value);
                    check_field("second_value", want.second_value,
                                result_if.data.second_value);
                    check_field("commit", want.commit, result_if.data.commit);
                end
            end
            // watchdog: too long with nothing moving on either channel
            if ((keys_if.valid && keys_if.ready) || (result_if.valid && result_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("[clock_time_set_editor_top] ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        int directed_count;
        int n;
        int pick;
        key_t k;

        clk             = 1'b0;
        rst_n           = 1'b0;
        keys_if.valid   = 1'b0;
        keys_if.data    = '0;
        result_if.ready = 1'b0;
        key_taken       = 1'b0;
        keys_accepted   = 0;
        quiet_cycles    = 0;
        errors          = 0;
        editor          = '{field: FLD_IDLE, tens: 1'b0, year: RST_YEAR, month: RST_MONTH,
                            day: RST_DAY, hour: RST_HOUR, minute: RST_MINUTE,
                            second: RST_SECOND};

        // --- directed part ---
        // keys while idle do nothing, and show the reset contents
        add_op(OP_ADD);
        add_op(OP_MINUS);
        add_op(OP_UNUSED);
        // out of range snapshot: year 127 folds to 27, the rest stays as given
        add_load(127, 15, 31, 31, 63, 63);
        // year tens: down through zero to 99, then up past 100 wraps to 9
        add_op(OP_MINUS);
        add_op(OP_MINUS);
        add_op(OP_MINUS);
        add_op(OP_ADD);
        add_sets(2);
        // month 15: tens up is refused, tens down gives 5
        add_op(OP_ADD);
        add_op(OP_MINUS);
        add_sets(2);
        // day 31 in a 31-day month: tens up is refused
        add_op(OP_ADD);
        // walk out through the remaining digits to the commit
        add_sets(8);
        // leap case: year 0 is a leap year, so February stretches to 29 but not 30
        add_load(0, 2, 28, 0, 0, 0);
        add_sets(5);
        add_op(OP_ADD);
        add_op(OP_ADD);
        directed_count = pending_keys.size();

        // --- random part: mostly complete edit sessions with random content ---
        while (pending_keys.size() < directed_count + RANDOM_KEYS)
        begin
            if ($urandom_range(7) == 0)
            begin
                // noise: any key, any time inputs
                repeat ($urandom_range(1, 8)) add_op(2'($urandom_range(3)));
            end
            else
            begin
                k = random_key(OP_SET);
                if ($urandom_range(9) != 0)
                begin
                    // plausible snapshot, biased towards leap years and February
                    pick = $urandom_range(3);
                    if (pick == 0)
                        k.now_year = 7'd0;
                    else if (pick == 1)
                        k.now_year = 7'(4 * $urandom_range(24));
                    else
                        k.now_year = 7'($urandom_range(99));
                    k.now_month  = ($urandom_range(2) == 0) ? 4'd2 : 4'($urandom_range(1, 12));
                    k.now_day    = $urandom_range(1) ? 5'($urandom_range(26, 31))
                                                     : 5'($urandom_range(1, 31));
                    k.now_hour   = 5'($urandom_range(23));
                    k.now_minute = 6'($urandom_range(59));
                    k.now_second = 6'($urandom_range(59));
                end
                pending_keys.push_back(k);
                // six fields, tens then units, a few steps on each digit
                repeat (12)
                begin
                    n = ($urandom_range(7) == 0) ? $urandom_range(4, 12) : $urandom_range(3);
                    add_edits(n);
                    add_op(OP_SET);
                end
            end
        end
        total_keys = pending_keys.size();

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // all requests out, then all results back, then a short tail for strays
        while (pending_keys.size() != 0 || keys_if.valid)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (expected_results.size() != 0)
        begin
            $error("%0d results never arrived", expected_results.size());
            errors++;
        end
        if (errors == 0)
            $display("[clock_time_set_editor_top] OK");
        else
            $display("[clock_time_set_editor_top] ERROR");
        $finish;
    end

endmodule

/* files.f */
rtl/core/ctse_pkg.sv
rtl/core/ctse_if.sv
rtl/core/ctse_step.sv
rtl/core/clock_time_set_editor_top.sv
test/tb.sv
